FILE: src/quadratic_root_solver_defines.svh
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication, checked on clk with arst_n low disabling
`define QRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/qrs_pkg.sv
// shared constants and types of the quadratic root solver
`default_nettype none
package qrs_pkg;
	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ROOT_BITS      = 33;
	localparam int DISC_BITS      = 34;
	localparam int STATUS_BITS    = 2;
	localparam int OUT_DATA_W     = ((2 * ROOT_BITS + DISC_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W      = OUT_DATA_W - 2 * ROOT_BITS - DISC_BITS;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_NONE   = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_TWO    = 2'd2,
		ST_A_ZERO = 2'd3
	} status_t;
endpackage
`default_nettype wire

FILE: src/qrs_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module qrs_sqrt #(
	parameter int XW = 34,
	parameter int TW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [XW-1:0]   x,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [XW/2-1:0] root,
	output logic [TW-1:0]   out_tag
);
	localparam int RW  = XW / 2;
	localparam int RMW = RW + 2;

	logic            v_s    [RW];
	logic [XW-1:0]   x_s    [RW];
	logic [RMW-1:0]  rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [TW-1:0]   tag_s  [RW];

	genvar i;
	for (i = 0; i < RW; i++) begin : g_stage
		logic           v_in;
		logic [XW-1:0]  x_in;
		logic [RMW-1:0] rem_in;
		logic [RW-1:0]  root_in;
		logic [TW-1:0]  tag_in;
		logic [RMW-1:0] rem_sh;
		logic [RMW-1:0] trial;
		logic           ge;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign x_in    = x;
			assign rem_in  = '0;
			assign root_in = '0;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign x_in    = x_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign tag_in  = tag_s[i-1];
		end

		assign rem_sh = {rem_in[RMW-3:0], x_in[XW-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]    <= x_in << 2;
				rem_s[i]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[i] <= {root_in[RW-2:0], ge};
				tag_s[i]  <= tag_in;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_tag   = tag_s[RW-1];
endmodule
`default_nettype wire

FILE: src/qrs_div.sv
// pipelined two-lane unsigned divider with a shared divisor, one quotient bit per stage
`default_nettype none
module qrs_div #(
	parameter int NW  = 33,
	parameter int DVW = 17,
	parameter int TW  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [NW-1:0]  num_p,
	input  logic [NW-1:0]  num_m,
	input  logic [DVW-1:0] den,
	input  logic [TW-1:0]  in_tag,
	output logic           out_valid,
	output logic [NW-1:0]  quo_p,
	output logic [NW-1:0]  quo_m,
	output logic [TW-1:0]  out_tag
);
	localparam int RDW = DVW + 1;

	logic           v_s     [NW];
	logic [NW-1:0]  np_s    [NW];
	logic [NW-1:0]  nm_s    [NW];
	logic [RDW-1:0] remp_s  [NW];
	logic [RDW-1:0] remm_s  [NW];
	logic [NW-1:0]  qp_s    [NW];
	logic [NW-1:0]  qm_s    [NW];
	logic [DVW-1:0] d_s     [NW];
	logic [TW-1:0]  tag_s   [NW];

	genvar i;
	for (i = 0; i < NW; i++) begin : g_stage
		logic           v_in;
		logic [NW-1:0]  np_in;
		logic [NW-1:0]  nm_in;
		logic [RDW-1:0] remp_in;
		logic [RDW-1:0] remm_in;
		logic [NW-1:0]  qp_in;
		logic [NW-1:0]  qm_in;
		logic [DVW-1:0] d_in;
		logic [TW-1:0]  tag_in;
		logic [RDW-1:0] shp;
		logic [RDW-1:0] shm;
		logic [RDW-1:0] dext;
		logic           gep;
		logic           gem;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign np_in   = num_p;
			assign nm_in   = num_m;
			assign remp_in = '0;
			assign remm_in = '0;
			assign qp_in   = '0;
			assign qm_in   = '0;
			assign d_in    = den;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign np_in   = np_s[i-1];
			assign nm_in   = nm_s[i-1];
			assign remp_in = remp_s[i-1];
			assign remm_in = remm_s[i-1];
			assign qp_in   = qp_s[i-1];
			assign qm_in   = qm_s[i-1];
			assign d_in    = d_s[i-1];
			assign tag_in  = tag_s[i-1];
		end

		assign dext = {1'b0, d_in};
		assign shp  = {remp_in[RDW-2:0], np_in[NW-1]};
		assign shm  = {remm_in[RDW-2:0], nm_in[NW-1]};
		assign gep  = (shp >= dext);
		assign gem  = (shm >= dext);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				np_s[i]   <= np_in << 1;
				nm_s[i]   <= nm_in << 1;
				remp_s[i] <= gep ? (shp - dext) : shp;
				remm_s[i] <= gem ? (shm - dext) : shm;
				qp_s[i]   <= {qp_in[NW-2:0], gep};
				qm_s[i]   <= {qm_in[NW-2:0], gem};
				d_s[i]    <= d_in;
				tag_s[i]  <= tag_in;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quo_p     = qp_s[NW-1];
	assign quo_m     = qm_s[NW-1];
	assign out_tag   = tag_s[NW-1];
endmodule
`default_nettype wire

FILE: src/quadratic_root_solver.sv
// top level of the quadratic root solver: real roots of a*x^2 + b*x + c = 0
//
// usage
//   s_tdata carries coef_a, coef_b, coef_c, each COEF_WIDTH bits two's complement
//   one transaction in gives exactly one transaction out, in order
//   m_tuser carries the status: none, double root, two roots, a was zero
//   m_tdata carries root_plus, root_minus (FRAC_BITS fraction bits) and the
//   exact discriminant; roots are zero for no real root or a zero a
// timing
//   a new transaction is taken every cycle while s_tready is high; results
//   pass through input capture, products, discriminant, the bit-per-stage
//   square root, numerators, the bit-per-stage divider and the output buffer
// reset and stall
//   arst_n clears all valid bits and the output buffer, nothing is pending
//   a two-entry output buffer takes results while m_tready is low; once it
//   is full the whole pipeline holds and s_tready falls, nothing is lost
`default_nettype none
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
	parameter int IN_W       = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [IN_W-1:0]                     s_tdata,   // coef_a, coef_b, coef_c, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [qrs_pkg::OUT_DATA_W-1:0]      m_tdata,   // root_plus, root_minus, discriminant, zero pad
	output logic [qrs_pkg::STATUS_BITS-1:0]     m_tuser    // status
);
	localparam int CW    = COEF_WIDTH;
	localparam int DLW   = 2 * CW + 2;
	localparam int RW    = DLW / 2;
	localparam int NUMW  = CW + 1;
	localparam int NW    = NUMW + FRAC_BITS;
	localparam int DVW   = CW + 1;
	localparam int SB    = qrs_pkg::STATUS_BITS;
	localparam int RB    = qrs_pkg::ROOT_BITS;
	localparam int DB    = qrs_pkg::DISC_BITS;
	localparam int QX    = ((NW > RB) ? NW : RB) + 1;
	localparam int STW   = SB + DLW + 2 * CW;
	localparam int DTW   = SB + DLW + 2;
	localparam int OW    = qrs_pkg::OUT_DATA_W + SB;
	localparam logic [QX-1:0] LIM_NEG = QX'(1) << (RB - 1);
	localparam logic [QX-1:0] LIM_POS = LIM_NEG - QX'(1);

	logic en;

	// stage 1: input capture
	logic                 v_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_tdata[CW-1:0];
			b_s1 <= s_tdata[2*CW-1:CW];
			c_s1 <= s_tdata[3*CW-1:2*CW];
		end
	end

	// stage 2: products
	logic                   v_s2;
	logic signed [2*CW-1:0] bb_s2, ac_s2;
	logic signed [CW-1:0]   a_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
		end
	end

	// stage 3: discriminant and classification
	logic signed [DLW-1:0] delta_c;
	qrs_pkg::status_t      status_c;
	logic                  v_s3;
	logic signed [DLW-1:0] delta_s3;
	qrs_pkg::status_t      status_s3;
	logic signed [CW-1:0]  a_s3, b_s3;

	always_comb begin
		delta_c = DLW'(bb_s2) - (DLW'(ac_s2) <<< 2);
		if (a_s2 == '0) begin
			status_c = qrs_pkg::ST_A_ZERO;
		end else if (delta_c < 0) begin
			status_c = qrs_pkg::ST_NONE;
		end else if (delta_c == '0) begin
			status_c = qrs_pkg::ST_DOUBLE;
		end else begin
			status_c = qrs_pkg::ST_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s3  <= delta_c;
			status_s3 <= status_c;
			a_s3      <= a_s2;
			b_s3      <= b_s2;
		end
	end

	// square root
	logic           sq_valid;
	logic [RW-1:0]  sq_root;
	logic [STW-1:0] sq_tag;

	qrs_sqrt #(
		.XW (DLW),
		.TW (STW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.x         (DLW'(delta_s3)),
		.in_tag    ({status_s3, delta_s3, a_s3, b_s3}),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	// stage 4: numerators, divisor and signs
	logic signed [CW-1:0]   sq_a, sq_b;
	logic [DLW-1:0]         sq_delta;
	logic [SB-1:0]          sq_status;
	logic signed [CW+1:0]   bneg, sroot, np_c, nm_c;
	logic signed [CW:0]     a2_c;
	logic [NUMW-1:0]        npm_c, nmm_c;
	logic                   v_s4;
	logic [NW-1:0]          np_s4, nm_s4;
	logic [DVW-1:0]         d_s4;
	logic                   negp_s4, negm_s4;
	logic [SB-1:0]          status_s4;
	logic [DLW-1:0]         delta_s4;

	assign {sq_status, sq_delta, sq_a, sq_b} = sq_tag;

	always_comb begin
		bneg  = -((CW+2)'(sq_b));
		sroot = $signed({1'b0, sq_root});
		np_c  = bneg + sroot;
		nm_c  = bneg - sroot;
		npm_c = NUMW'((np_c < 0) ? -np_c : np_c);
		nmm_c = NUMW'((nm_c < 0) ? -nm_c : nm_c);
		a2_c  = (CW+1)'(sq_a) <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s4     <= NW'(npm_c) << FRAC_BITS;
			nm_s4     <= NW'(nmm_c) << FRAC_BITS;
			d_s4      <= (a2_c < 0) ? DVW'(-a2_c) : DVW'(a2_c);
			negp_s4   <= (np_c < 0) ^ (sq_a < 0);
			negm_s4   <= (nm_c < 0) ^ (sq_a < 0);
			status_s4 <= sq_status;
			delta_s4  <= sq_delta;
		end
	end

	// division
	logic           dv_valid;
	logic [NW-1:0]  dv_qp, dv_qm;
	logic [DTW-1:0] dv_tag;

	qrs_div #(
		.NW  (NW),
		.DVW (DVW),
		.TW  (DTW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num_p     (np_s4),
		.num_m     (nm_s4),
		.den       (d_s4),
		.in_tag    ({status_s4, delta_s4, negp_s4, negm_s4}),
		.out_valid (dv_valid),
		.quo_p     (dv_qp),
		.quo_m     (dv_qm),
		.out_tag   (dv_tag)
	);

	// final: sign, saturation, zeroing
	function automatic logic [RB-1:0] fix_root(input logic [NW-1:0] q, input logic neg);
		logic [QX-1:0] qx;
		logic [QX-1:0] sat;
		qx = QX'(q);
		if (neg) begin
			sat = (qx > LIM_NEG) ? LIM_NEG : qx;
			return RB'(QX'(0) - sat);
		end
		sat = (qx > LIM_POS) ? LIM_POS : qx;
		return RB'(sat);
	endfunction

	logic [SB-1:0]         fin_status;
	logic signed [DLW-1:0] fin_delta;
	logic                  fin_negp, fin_negm;
	logic [RB-1:0]         rp_c, rm_c;
	logic [OW-1:0]         push_word;

	assign {fin_status, fin_delta, fin_negp, fin_negm} = dv_tag;

	always_comb begin
		if (fin_status == qrs_pkg::ST_NONE || fin_status == qrs_pkg::ST_A_ZERO) begin
			rp_c = '0;
			rm_c = '0;
		end else begin
			rp_c = fix_root(dv_qp, fin_negp);
			rm_c = fix_root(dv_qm, fin_negm);
		end
		push_word = {qrs_pkg::OUT_PAD_W'(0), DB'(fin_delta), rm_c, rp_c,
			fin_status};
	end

	// two-entry output buffer
	logic [OW-1:0] buf_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign push     = en && dv_valid;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = buf_q[rd_ptr_q][SB-1:0];
	assign m_tdata  = buf_q[rd_ptr_q][OW-1:SB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_word;
		end
	end

	// output fields seen by the checks
	logic [RB-1:0] out_rp, out_rm;
	logic [DB-1:0] out_disc;
	logic          out_dbl, out_zero, out_two;

	assign out_rp   = m_tdata[RB-1:0];
	assign out_rm   = m_tdata[2*RB-1:RB];
	assign out_disc = m_tdata[2*RB+DB-1:2*RB];
	assign out_dbl  = m_tvalid && m_tuser == qrs_pkg::ST_DOUBLE;
	assign out_zero = m_tvalid && (m_tuser == qrs_pkg::ST_NONE || m_tuser == qrs_pkg::ST_A_ZERO);
	assign out_two  = m_tvalid && m_tuser == qrs_pkg::ST_TWO;

	`QRS_ASSERT_IMP(a_ready_only_when_full, !s_tready, cnt_q == 2'd2, "ready low with room")
	`QRS_ASSERT_IMP(a_double_equal, out_dbl, out_rp == out_rm, "double root differs")
	`QRS_ASSERT_IMP(a_zero_roots, out_zero, out_rp == '0 && out_rm == '0, "roots not zero")
	`QRS_ASSERT_IMP(a_two_positive, out_two, !out_disc[DB-1] && out_disc != '0, "two roots, bad disc")
	`QRS_ASSERT_NXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
endmodule
`default_nettype wire
